/* hdl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, types and status bundle for the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int WIDTH = 32;
	// Signed headroom for 2*acc + x - 2*m with acc, x < m < 2^WIDTH.
	localparam int XW    = WIDTH + 3;
	localparam int CNT_W = $clog2(WIDTH);

	typedef logic [WIDTH-1:0]        word_t;
	typedef logic signed [XW-1:0]    ext_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	// Status of the modular multiplier as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage

/* hdl/mexp_modmul.sv */
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_modmul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mexp_pkg::word_t      x,
	input  mexp_pkg::word_t      y,
	input  mexp_pkg::word_t      m,
	output mexp_pkg::mm_status_t status,
	output mexp_pkg::word_t      product
);

	logic            busy_q;
	logic            done_q;
	mexp_pkg::cnt_t  cnt_q;
	mexp_pkg::word_t acc_q;
	mexp_pkg::word_t y_q;
	mexp_pkg::ext_t  a_x_q;
	mexp_pkg::ext_t  a_xm1_q;
	mexp_pkg::ext_t  a_xm2_q;
	mexp_pkg::ext_t  a_m1_q;
	mexp_pkg::ext_t  a_m2_q;

	mexp_pkg::ext_t  ext_x;
	mexp_pkg::ext_t  ext_m;
	mexp_pkg::ext_t  dbl;
	mexp_pkg::ext_t  add0;
	mexp_pkg::ext_t  add1;
	mexp_pkg::ext_t  add2;
	mexp_pkg::ext_t  t0;
	mexp_pkg::ext_t  t1;
	mexp_pkg::ext_t  t2;
	mexp_pkg::word_t acc_nxt;
	logic            ybit;

	assign ext_x = mexp_pkg::ext_t'({3'b000, x});
	assign ext_m = mexp_pkg::ext_t'({3'b000, m});
	assign dbl   = mexp_pkg::ext_t'({2'b00, acc_q, 1'b0});
	assign ybit  = y_q[mexp_pkg::WIDTH-1];

	// Three candidates 2*acc + x*bit - k*m, k = 0..2; keep the largest k that stays >= 0.
	always_comb begin
		add0 = ybit ? a_x_q   : '0;
		add1 = ybit ? a_xm1_q : a_m1_q;
		add2 = ybit ? a_xm2_q : a_m2_q;
		t0   = dbl + add0;
		t1   = dbl + add1;
		t2   = dbl + add2;
		priority if (!t2[mexp_pkg::XW-1]) begin
			acc_nxt = t2[mexp_pkg::WIDTH-1:0];
		end else if (!t1[mexp_pkg::XW-1]) begin
			acc_nxt = t1[mexp_pkg::WIDTH-1:0];
		end else begin
			acc_nxt = t0[mexp_pkg::WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + mexp_pkg::cnt_t'(1);
				if (cnt_q == mexp_pkg::cnt_t'(mexp_pkg::WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q   <= '0;
			y_q     <= y;
			a_x_q   <= ext_x;
			a_xm1_q <= ext_x - ext_m;
			a_xm2_q <= ext_x - (ext_m <<< 1);
			a_m1_q  <= '0 - ext_m;
			a_m2_q  <= '0 - (ext_m <<< 1);
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			y_q   <= {y_q[mexp_pkg::WIDTH-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = acc_q;

endmodule

/* hdl/modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: drive base, exponent, modulus and raise start; the beat is
//   taken on a rising edge with start high and busy low. busy stays high
//   while the command is worked on and drops in the cycle that carries the
//   result beat, so the next command beat may be taken on the same edge.
//   Result beat: result is valid for exactly one cycle while done is high.
//   The receiver cannot stall; the beat must be taken in that cycle.
// Sequence:
//   All work goes through one bit-serial modular multiplier. The base is
//   first reduced by one pass (1 * base mod modulus). Then each exponent
//   bit up to the top set bit costs one squaring, plus one multiply when
//   the bit is set; the square after the top set bit is skipped. Worst
//   case (all ones): one multiply per exponent bit and one squaring per
//   bit below the top. Exponent 0 finishes after the reduction pass;
//   modulus 0 yields 0 without a multiplier pass.
// Throughput: one command at a time.
// Reset: arst_n clears the sequencer and the multiplier; no beat is pending.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mexp_pkg::word_t       base,
	input  mexp_pkg::word_t       exponent,
	input  mexp_pkg::word_t       modulus,
	output logic                  busy,
	output logic                  done,
	output mexp_pkg::word_t       result
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;  // modulus of zero: answer 0
	localparam logic [2:0] ST_RED  = 3'd2;  // reduce base mod modulus
	localparam logic [2:0] ST_MUL  = 3'd3;  // acc = acc * sq
	localparam logic [2:0] ST_SQR  = 3'd4;  // sq = sq * sq

	logic [2:0]           state_q;
	logic [2:0]           state_nxt;
	mexp_pkg::word_t      acc_q;
	mexp_pkg::word_t      sq_q;
	mexp_pkg::word_t      exp_q;
	mexp_pkg::word_t      m_q;
	logic                 done_q;
	mexp_pkg::word_t      result_q;

	mexp_pkg::word_t      acc_nxt;
	mexp_pkg::word_t      sq_nxt;
	mexp_pkg::word_t      exp_nxt;
	mexp_pkg::word_t      exp_shr;
	mexp_pkg::word_t      one_mod;
	logic                 launch;
	mexp_pkg::word_t      op_x;
	mexp_pkg::word_t      op_y;
	mexp_pkg::word_t      op_m;
	logic                 fin;
	mexp_pkg::word_t      fin_val;

	mexp_pkg::mm_status_t mm_status;
	mexp_pkg::word_t      mm_product;

	mexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (launch),
		.x       (op_x),
		.y       (op_y),
		.m       (op_m),
		.status  (mm_status),
		.product (mm_product)
	);

	// 1 mod m: zero when the modulus is one.
	assign one_mod = (m_q == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
	assign exp_shr = exp_q >> 1;

	always_comb begin
		state_nxt = state_q;
		acc_nxt   = acc_q;
		sq_nxt    = sq_q;
		exp_nxt   = exp_q;
		launch    = 1'b0;
		op_x      = acc_q;
		op_y      = sq_q;
		op_m      = m_q;
		fin       = 1'b0;
		fin_val   = acc_q;
		unique case (state_q)
			ST_IDLE: begin
				// Reduction pass: (1 mod m) * base, scanning all base bits.
				op_m = modulus;
				op_x = (modulus == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
				op_y = base;
				if (start) begin
					exp_nxt = exponent;
					if (modulus == '0) begin
						state_nxt = ST_ZERO;
					end else begin
						launch    = 1'b1;
						state_nxt = ST_RED;
					end
				end
			end
			ST_ZERO: begin
				fin       = 1'b1;
				fin_val   = '0;
				state_nxt = ST_IDLE;
			end
			ST_RED: begin
				if (mm_status.done) begin
					acc_nxt = one_mod;
					sq_nxt  = mm_product;
					// Decide on the lowest exponent bit.
					if (exp_q == '0) begin
						fin       = 1'b1;
						fin_val   = one_mod;
						state_nxt = ST_IDLE;
					end else if (exp_q[0]) begin
						launch    = 1'b1;
						op_x      = one_mod;
						op_y      = mm_product;
						state_nxt = ST_MUL;
					end else begin
						launch    = 1'b1;
						op_x      = mm_product;
						op_y      = mm_product;
						state_nxt = ST_SQR;
					end
				end
			end
			ST_MUL: begin
				if (mm_status.done) begin
					acc_nxt = mm_product;
					// Drop the final square when no higher bit is set.
					if (exp_shr == '0) begin
						fin       = 1'b1;
						fin_val   = mm_product;
						state_nxt = ST_IDLE;
					end else begin
						launch    = 1'b1;
						op_x      = sq_q;
						op_y      = sq_q;
						state_nxt = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mm_status.done) begin
					sq_nxt  = mm_product;
					exp_nxt = exp_shr;
					// Advance to the next exponent bit.
					if (exp_shr == '0) begin
						fin       = 1'b1;
						fin_val   = acc_q;
						state_nxt = ST_IDLE;
					end else if (exp_shr[0]) begin
						launch    = 1'b1;
						op_x      = acc_q;
						op_y      = mm_product;
						state_nxt = ST_MUL;
					end else begin
						launch    = 1'b1;
						op_x      = mm_product;
						op_y      = mm_product;
						state_nxt = ST_SQR;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= fin;
		end
	end

	// Payload registers: hold operands between multiplier passes.
	always_ff @(posedge clk) begin
		acc_q <= acc_nxt;
		sq_q  <= sq_nxt;
		exp_q <= exp_nxt;
		if (state_q == ST_IDLE && start) begin
			m_q <= modulus;
		end
		if (fin) begin
			result_q <= fin_val;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* hdl/mexp_checker.sv */
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the command/result sequencing of the core.
// ----------------------------------------------------------------------------
module mexp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input mexp_pkg::word_t result
);

	// An accepted command beat makes the core busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command beat accepted but core not busy");

	// A result beat follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without preceding work");

	// The core is idle while it delivers a result beat.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	// One result beat per command: the strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// A result beat carries a defined value.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result beat carries unknown bits");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
